[rtl/core/lrf_pkg.sv]
// Shared types and constants of the lidar return filter with scan cut detection.
`default_nettype none
package lrf_pkg;

    // One full turn in hundredths of a degree
    localparam logic [15:0] C_FULL_TURN = 16'd36000;

    // Number of laser channels that carry points; channels at or above give none
    localparam int C_LASERS = 64;
    localparam int C_LASER_CMP_W = 9;

    // Job queue between the classifier and the output sequencer
    localparam int C_QDEPTH = 4;
    localparam int C_QPTR_W = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CUT_PHASE = 2'd0;
    localparam logic [1:0] CFG_MIN_RANGE = 2'd1;
    localparam logic [1:0] CFG_MAX_RANGE = 2'd2;
    localparam logic [1:0] CFG_MERGE_THR = 2'd3;

    // Register reset values
    localparam logic [15:0] C_RST_CUT_PHASE = 16'd0;
    localparam logic [23:0] C_RST_MIN_RANGE = 24'd100;
    localparam logic [23:0] C_RST_MAX_RANGE = 24'd60000;
    localparam logic [23:0] C_RST_MERGE_THR = 24'd0;

    // Return kinds
    localparam logic [1:0] K_FIRST = 2'd0;
    localparam logic [1:0] K_LAST  = 2'd1;
    localparam logic [1:0] K_IDENT = 2'd2;

    // One input transaction: one laser channel of one firing
    typedef struct packed {
        logic        packet_begin;
        logic        block_begin;
        logic        dual_mode;
        logic        single_is_first;
        logic [15:0] block_azimuth;
        logic [5:0]  laser;
        logic [7:0]  range_unit;
        logic [15:0] range_first;
        logic [15:0] range_last;
        logic [7:0]  intensity_first;
        logic [7:0]  intensity_last;
    } t_in;

    // One result transaction
    typedef struct packed {
        logic        point_valid;
        logic [5:0]  channel;
        logic [23:0] distance_mm;
        logic [7:0]  intensity;
        logic [1:0]  return_kind;
        logic        scan_cut;
        logic        last;
    } t_out;

    // One queued job: up to two results caused by one input transaction
    typedef struct packed {
        t_out res0;
        t_out res1;
        logic two;
    } t_job;

endpackage
`default_nettype wire

[rtl/core/lrf_front.sv]
// Front end: input register, range scaling, phase check and point classification.
`default_nettype none
module lrf_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr_en,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [23:0]         i_cfg_data,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  lrf_pkg::t_in  i_item,
    output logic                o_push,
    output lrf_pkg::t_job       o_job,
    input  wire                 i_full
);
    import lrf_pkg::*;

    // Configuration registers; cut phase is kept reduced to one turn
    logic [15:0] r_cut_phase;
    logic [23:0] r_min_range;
    logic [23:0] r_max_range;
    logic [23:0] r_merge_thr;

    // Per-packet scan state
    logic [15:0] r_prev_phase;
    logic        r_cut_in_packet;

    // Input stage
    logic        r_s1_v;
    logic        r_packet_begin;
    logic        r_block_begin;
    logic        r_dual_mode;
    logic        r_single_is_first;
    logic [15:0] r_az_mod;
    logic [5:0]  r_laser;
    logic [23:0] r_d1;
    logic [23:0] r_d2;
    logic [7:0]  r_i1;
    logic [7:0]  r_i2;

    logic [15:0] cfg_cp_mod;
    logic [15:0] az_mod;
    logic        accept;
    logic        adv;
    logic [16:0] phase_diff;
    logic [16:0] phase_wrap;
    logic [15:0] phase;
    logic        rising;
    logic        cip;
    logic        cut;
    logic        n_cut_in_packet;
    logic        ok1;
    logic        ok2;
    logic [23:0] dist_diff;
    logic        merge;
    logic        in_range_laser;
    logic [1:0]  n_pts;
    t_out        res0;
    t_out        res1;
    logic        has_res;

    // Configuration writes
    always_comb begin
        cfg_cp_mod = (i_cfg_data[15:0] >= C_FULL_TURN) ?
                     (i_cfg_data[15:0] - C_FULL_TURN) : i_cfg_data[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_phase <= C_RST_CUT_PHASE;
            r_min_range <= C_RST_MIN_RANGE;
            r_max_range <= C_RST_MAX_RANGE;
            r_merge_thr <= C_RST_MERGE_THR;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CUT_PHASE: r_cut_phase <= cfg_cp_mod;
                CFG_MIN_RANGE: r_min_range <= i_cfg_data;
                CFG_MAX_RANGE: r_max_range <= i_cfg_data;
                CFG_MERGE_THR: r_merge_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the input stage moves on when its job fits in the queue
    assign adv     = r_s1_v && (!i_full || !has_res);
    assign o_stall = r_s1_v && !adv;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        az_mod = (i_item.block_azimuth >= C_FULL_TURN) ?
                 (i_item.block_azimuth - C_FULL_TURN) : i_item.block_azimuth;
    end

    // Input stage: scale ranges and reduce azimuth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_packet_begin    <= i_item.packet_begin;
            r_block_begin     <= i_item.block_begin;
            r_dual_mode       <= i_item.dual_mode;
            r_single_is_first <= i_item.single_is_first;
            r_az_mod          <= az_mod;
            r_laser           <= i_item.laser;
            r_d1              <= 24'(i_item.range_first * i_item.range_unit);
            r_d2              <= 24'(i_item.range_last * i_item.range_unit);
            r_i1              <= i_item.intensity_first;
            r_i2              <= i_item.intensity_last;
        end
    end

    // Phase relative to the cut angle and scan cut decision
    always_comb begin
        phase_diff = {1'b0, r_az_mod} - {1'b0, r_cut_phase};
        phase_wrap = phase_diff + {1'b0, C_FULL_TURN};
        phase      = phase_diff[16] ? phase_wrap[15:0] : phase_diff[15:0];
        rising     = phase > r_prev_phase;
        cip        = r_packet_begin ? 1'b0 : r_cut_in_packet;
        if (r_block_begin) begin
            cut             = !cip && !rising;
            n_cut_in_packet = cip || !rising;
        end else begin
            cut             = 1'b0;
            n_cut_in_packet = cip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase    <= 16'd0;
            r_cut_in_packet <= 1'b0;
        end else if (adv) begin
            r_cut_in_packet <= n_cut_in_packet;
            if (r_block_begin) begin
                r_prev_phase <= phase;
            end
        end
    end

    // Range window, dual-return merge and result build
    always_comb begin
        ok1            = (r_d1 > r_min_range) && (r_d1 <= r_max_range);
        ok2            = (r_d2 > r_min_range) && (r_d2 <= r_max_range);
        dist_diff      = (r_d1 > r_d2) ? (r_d1 - r_d2) : (r_d2 - r_d1);
        merge          = (dist_diff < r_merge_thr) && ok2;
        in_range_laser = {3'b000, r_laser} < C_LASER_CMP_W'(C_LASERS);

        res0.point_valid = 1'b1;
        res0.channel     = r_laser;
        res0.scan_cut    = cut;
        res0.last        = 1'b1;
        res0.distance_mm = r_d1;
        res0.intensity   = r_i1;
        res0.return_kind = K_FIRST;
        n_pts            = 2'd0;

        res1.point_valid = 1'b1;
        res1.channel     = r_laser;
        res1.distance_mm = r_d2;
        res1.intensity   = r_i2;
        res1.return_kind = K_LAST;
        res1.scan_cut    = 1'b0;
        res1.last        = 1'b1;

        if (!r_dual_mode) begin
            n_pts            = {1'b0, ok1};
            res0.return_kind = r_single_is_first ? K_FIRST : K_LAST;
        end else if (merge) begin
            n_pts            = 2'd1;
            res0.distance_mm = r_d2;
            res0.intensity   = r_i2;
            res0.return_kind = K_IDENT;
        end else if (ok1) begin
            n_pts = ok2 ? 2'd2 : 2'd1;
        end else begin
            n_pts            = {1'b0, ok2};
            res0.distance_mm = r_d2;
            res0.intensity   = r_i2;
            res0.return_kind = K_LAST;
        end

        if (!in_range_laser) begin
            n_pts = 2'd0;
        end

        // Cut marker when no point comes out
        if (n_pts == 2'd0) begin
            res0.point_valid = 1'b0;
            res0.distance_mm = 24'd0;
            res0.intensity   = 8'd0;
            res0.return_kind = K_FIRST;
        end
        res0.last = (n_pts != 2'd2);
        has_res   = (n_pts != 2'd0) || cut;
    end

    assign o_push    = adv && has_res;
    assign o_job     = '{res0: res0, res1: res1, two: (n_pts == 2'd2)};

endmodule
`default_nettype wire

[rtl/core/lrf_queue.sv]
// Short job queue that decouples the classifier from the output sequencer.
`default_nettype none
module lrf_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire  lrf_pkg::t_job i_job,
    output logic                o_full,
    input  wire                 i_pop,
    output lrf_pkg::t_job       o_head,
    output logic                o_empty
);
    import lrf_pkg::*;

    t_job                r_mem [C_QDEPTH];
    logic [C_QPTR_W-1:0] r_wr;
    logic [C_QPTR_W-1:0] r_rd;
    logic [C_QPTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (C_QPTR_W+1)'(C_QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

[rtl/core/lrf_back.sv]
// Back end: steps through queued jobs and drives the result register.
`default_nettype none
module lrf_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  lrf_pkg::t_job i_head,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output lrf_pkg::t_out       o_result
);
    import lrf_pkg::*;

    logic r_valid;
    logic r_sel;
    t_out r_result;
    logic load;
    logic take;

    // The result register reloads when empty or when its transaction completes
    assign load  = !r_valid || !i_stall;
    assign take  = load && !i_empty;
    assign o_pop = take && (r_sel || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (take) begin
                r_sel <= !r_sel && i_head.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= r_sel ? i_head.res1 : i_head.res0;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

[rtl/core/lidar_return_filter_scan_cut.sv]
// Top level of the lidar return filter with scan cut detection.
// Takes one laser channel per transaction, scales both ranges to millimetres,
// applies the range window and the dual-return merge, and flags the first
// non-rising phase in a packet as a scan cut. An input transaction is taken
// every cycle unless o_stall is high; it passes an input register (two 16x8
// range multipliers), a classifier that updates the phase state and writes a
// job into a four-entry queue, and an output register that emits one result
// per cycle while i_stall is low. A channel with two points sends both
// results through the output register one after the other, so a stream of
// dual-point channels fills the queue and stalls the input; the queue absorbs
// short bursts. The first result of a transaction is presented once it has
// passed the input register, a queue entry and the output register.
`default_nettype none
module lidar_return_filter_scan_cut (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr_en,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [23:0]         i_cfg_data,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  lrf_pkg::t_in  i_item,
    output logic                o_valid,
    input  wire                 i_stall,
    output lrf_pkg::t_out       o_result
);
    import lrf_pkg::*;

    logic push;
    t_job job;
    logic full;
    logic pop;
    t_job head;
    logic empty;

    lrf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_push      (push),
        .o_job       (job),
        .i_full      (full)
    );

    lrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    lrf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the lidar return filter with scan cut detection.
`timescale 1ns / 100ps
module testbench;
    import lrf_pkg::*;

    localparam int LAT_SLACK = 8;

    // Clock, reset and DUT ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = CFG_CUT_PHASE;
    logic [23:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_in         i_item      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_out        o_result;

    // Filter model: register copies and scan state
    logic [15:0] cut_phase_r = C_RST_CUT_PHASE;
    logic [23:0] min_r       = C_RST_MIN_RANGE;
    logic [23:0] max_r       = C_RST_MAX_RANGE;
    logic [23:0] merge_r     = C_RST_MERGE_THR;
    logic [15:0] prev_phase  = '0;
    bit          cut_in_pkt  = 1'b0;
    bit          cut_pend    = 1'b0;

    // Stimulus and scoreboard bookkeeping
    t_in  pending_items[$];
    t_out expected_points[$];
    t_out oldest_point;
    int   items_queued   = 0;
    int   items_taken    = 0;
    int   mismatch_count = 0;
    int   idle_pct       = 38;
    int   scan_az        = 0;
    bit   item_taken     = 1'b0;

    lidar_return_filter_scan_cut dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit in_window(input logic [31:0] d);
        return d > 32'(min_r) && d <= 32'(max_r);
    endfunction

    function automatic t_out make_point(input logic valid, input logic [5:0] ch,
                                        input logic [23:0] dist_mm, input logic [7:0] inten,
                                        input logic [1:0] kind);
        t_out p;
        p.point_valid = valid;
        p.channel     = ch;
        p.distance_mm = dist_mm;
        p.intensity   = inten;
        p.return_kind = kind;
        p.scan_cut    = 1'b0;
        p.last        = 1'b0;
        return p;
    endfunction

    // Work out the points (and cut marker) one accepted transaction gives
    function automatic void predict_returns(input t_in it);
        logic [31:0] d1, d2, diff, phase;
        t_out        res [2];
        int          n;
        bit          ok1, ok2;
        n  = 0;
        d1 = 32'(it.range_first) * 32'(it.range_unit);
        d2 = 32'(it.range_last) * 32'(it.range_unit);
        if (it.packet_begin)
            cut_in_pkt = 1'b0;
        // phase against the cut angle, both reduced to one turn
        if (it.block_begin) begin
            phase = (32'(it.block_azimuth) % 32'(C_FULL_TURN) + 32'(C_FULL_TURN)
                     - 32'(cut_phase_r) % 32'(C_FULL_TURN)) % 32'(C_FULL_TURN);
            if (!(phase > 32'(prev_phase) && !cut_in_pkt)) begin
                if (!cut_in_pkt)
                    cut_pend = 1'b1;
                cut_in_pkt = 1'b1;
            end
            prev_phase = phase[15:0];
        end
        if (int'(it.laser) < C_LASERS) begin
            ok1  = in_window(d1);
            ok2  = in_window(d2);
            diff = (d1 > d2) ? d1 - d2 : d2 - d1;
            if (!it.dual_mode) begin
                if (ok1) begin
                    res[n] = make_point(1'b1, it.laser, d1[23:0], it.intensity_first,
                                        it.single_is_first ? K_FIRST : K_LAST);
                    n++;
                end
            end else if (diff < 32'(merge_r) && ok2) begin
                res[n] = make_point(1'b1, it.laser, d2[23:0], it.intensity_last, K_IDENT);
                n++;
            end else begin
                if (ok1) begin
                    res[n] = make_point(1'b1, it.laser, d1[23:0], it.intensity_first, K_FIRST);
                    n++;
                end
                if (ok2) begin
                    res[n] = make_point(1'b1, it.laser, d2[23:0], it.intensity_last, K_LAST);
                    n++;
                end
            end
        end
        // cut flag rides on the first result, or on a bare marker
        if (cut_pend) begin
            if (n == 0) begin
                res[0] = make_point(1'b0, it.laser, '0, '0, K_FIRST);
                n = 1;
            end
            res[0].scan_cut = 1'b1;
            cut_pend = 1'b0;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_points = {expected_points, res[k]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Input acceptance and result checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            predict_returns(i_item);
            items_taken++;
            item_taken = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(o_result.distance_mm),
                                32'd0);
            end else begin
                oldest_point = expected_points.pop_front();
                if (o_result.point_valid !== oldest_point.point_valid)
                    report_mismatch("point_valid", 32'(o_result.point_valid),
                                    32'(oldest_point.point_valid));
                if (o_result.channel !== oldest_point.channel)
                    report_mismatch("channel", 32'(o_result.channel),
                                    32'(oldest_point.channel));
                if (o_result.distance_mm !== oldest_point.distance_mm)
                    report_mismatch("distance_mm", 32'(o_result.distance_mm),
                                    32'(oldest_point.distance_mm));
                if (o_result.intensity !== oldest_point.intensity)
                    report_mismatch("intensity", 32'(o_result.intensity),
                                    32'(oldest_point.intensity));
                if (o_result.return_kind !== oldest_point.return_kind)
                    report_mismatch("return_kind", 32'(o_result.return_kind),
                                    32'(oldest_point.return_kind));
                if (o_result.scan_cut !== oldest_point.scan_cut)
                    report_mismatch("scan_cut", 32'(o_result.scan_cut),
                                    32'(oldest_point.scan_cut));
                if (o_result.last !== oldest_point.last)
                    report_mismatch("last", 32'(o_result.last), 32'(oldest_point.last));
            end
        end
    end

    // Channel driver: holds a stalled transaction, otherwise sends or idles
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || item_taken) begin
            item_taken = 1'b0;
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_item  <= pending_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver back-pressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < idle_pct);
    end

    task automatic queue_item(input t_in it);
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    function automatic t_in mk_item(input bit pb, input bit bb, input bit dual, input bit sif,
                                    input logic [15:0] az, input logic [5:0] las,
                                    input logic [7:0] unit, input logic [15:0] r1,
                                    input logic [15:0] r2, input logic [7:0] i1,
                                    input logic [7:0] i2);
        t_in it;
        it.packet_begin    = pb;
        it.block_begin     = bb;
        it.dual_mode       = dual;
        it.single_is_first = sif;
        it.block_azimuth   = az;
        it.laser           = las;
        it.range_unit      = unit;
        it.range_first     = r1;
        it.range_last      = r2;
        it.intensity_first = i1;
        it.intensity_last  = i2;
        return it;
    endfunction

    // Raw range aimed mostly at the window and its edges
    function automatic logic [15:0] pick_range(input logic [7:0] unit);
        int v, u;
        u = int'(unit);
        if (u == 0)
            return 16'($urandom);
        case ($urandom_range(4))
            0:       v = $urandom_range(65535);
            1:       v = int'(min_r) / u + int'($urandom_range(2)) - 1;
            2:       v = int'(max_r) / u + int'($urandom_range(2)) - 1;
            default: v = $urandom_range(int'(max_r), int'(min_r)) / u;
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // Well-formed packets of firing blocks with random content, plus some noise
    task automatic queue_scan_items(input int n);
        int          made, blocks, chans, base, v;
        bit          dual, sif;
        logic [7:0]  unit;
        logic [95:0] noise;
        t_in         it;
        made = 0;
        while (made < n) begin
            if ($urandom_range(99) < 12) begin
                noise = {$urandom, $urandom, $urandom};
                it = noise[$bits(t_in)-1:0];
                queue_item(it);
                made++;
            end else begin
                dual   = 1'($urandom_range(1));
                sif    = 1'($urandom_range(1));
                unit   = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
                blocks = $urandom_range(1, 6);
                chans  = $urandom_range(1, 6);
                base   = $urandom_range(63);
                for (int b = 0; b < blocks; b++) begin
                    // mostly rising azimuth, now and then a step back
                    if ($urandom_range(9) == 0)
                        scan_az = (scan_az + 36000 - int'($urandom_range(400))) % 36000;
                    else
                        scan_az = (scan_az + int'($urandom_range(1, 2500))) % 36000;
                    for (int c = 0; c < chans; c++) begin
                        it.packet_begin    = (b == 0 && c == 0);
                        it.block_begin     = (c == 0) ^ ($urandom_range(19) == 0);
                        it.dual_mode       = dual;
                        it.single_is_first = sif;
                        v = scan_az;
                        if (scan_az < 29536 && $urandom_range(7) == 0)
                            v = scan_az + 36000;
                        it.block_azimuth   = 16'(v);
                        it.laser           = 6'(base + c);
                        it.range_unit      = unit;
                        it.range_first     = pick_range(unit);
                        if ($urandom_range(2) == 0) begin
                            it.range_last = pick_range(unit);
                        end else begin
                            v = int'(it.range_first) + int'($urandom_range(80)) - 40;
                            if (v < 0)
                                v = 0;
                            if (v > 65535)
                                v = 65535;
                            it.range_last = 16'(v);
                        end
                        it.intensity_first = 8'($urandom);
                        it.intensity_last  = 8'($urandom);
                        queue_item(it);
                        made++;
                    end
                end
            end
        end
    endtask

    // Wait until every queued transaction is in and every result is out
    task automatic wait_idle();
        while (items_taken != items_queued || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (LAT_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_CUT_PHASE: cut_phase_r = val[15:0];
            CFG_MIN_RANGE: min_r       = val;
            CFG_MAX_RANGE: max_r       = val;
            CFG_MERGE_THR: merge_r     = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] cut, input logic [23:0] lo,
                              input logic [23:0] hi, input logic [23:0] thr);
        wait_idle();
        write_reg(CFG_CUT_PHASE, 24'(cut));
        write_reg(CFG_MIN_RANGE, lo);
        write_reg(CFG_MAX_RANGE, hi);
        write_reg(CFG_MERGE_THR, thr);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // One random phase; the sender holds off midway until all results are back
    task automatic run_phase(input logic [15:0] cut, input logic [23:0] lo,
                             input logic [23:0] hi, input logic [23:0] thr,
                             input int n, input int idle);
        set_config(cut, lo, hi, thr);
        idle_pct = idle;
        queue_scan_items(n / 2);
        wait_idle();
        queue_scan_items(n - n / 2);
    endtask

    // Main sequence
    initial begin
        logic [23:0] lo;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: single returns of both kinds, phase drop, window edges
        queue_item(mk_item(1'b1, 1'b1, 1'b0, 1'b1, 16'd100, 6'd0, 8'd1, 16'd5000, 16'd0,
                           8'd255, 8'd0));
        queue_item(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 16'd100, 6'd63, 8'd255, 16'd200, 16'd777,
                           8'd1, 8'd9));
        queue_item(mk_item(1'b0, 1'b1, 1'b0, 1'b1, 16'd50, 6'd5, 8'd1, 16'd0, 16'd0, 8'd3,
                           8'd4));
        queue_item(mk_item(1'b0, 1'b1, 1'b0, 1'b1, 16'd40, 6'd6, 8'd1, 16'd100, 16'd0, 8'd3,
                           8'd4));
        queue_item(mk_item(1'b1, 1'b1, 1'b1, 1'b0, 16'd65535, 6'd7, 8'd1, 16'd1000, 16'd1000,
                           8'd10, 8'd20));

        // merges, window edges, cut handling within and across packets
        set_config(16'd18000, 24'd100, 24'd60000, 24'd300);
        queue_item(mk_item(1'b1, 1'b1, 1'b1, 1'b0, 16'd18000, 6'd1, 8'd1, 16'd2000, 16'd2100,
                           8'd11, 8'd22));
        queue_item(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 16'd18000, 6'd2, 8'd1, 16'd3000, 16'd3300,
                           8'd12, 8'd23));
        queue_item(mk_item(1'b0, 1'b0, 1'b1, 1'b1, 16'd18000, 6'd3, 8'd2, 16'd50, 16'd60,
                           8'd13, 8'd24));
        queue_item(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 16'd18000, 6'd4, 8'd1, 16'd59900,
                           16'd60001, 8'd14, 8'd25));
        queue_item(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 16'd18000, 6'd8, 8'd255, 16'd0, 16'd65535,
                           8'd15, 8'd26));
        queue_item(mk_item(1'b0, 1'b1, 1'b0, 1'b1, 16'd0, 6'd9, 8'd1, 16'd60000, 16'd0,
                           8'd16, 8'd0));
        queue_item(mk_item(1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 6'd10, 8'd1, 16'd101, 16'd0,
                           8'd17, 8'd0));
        queue_item(mk_item(1'b0, 1'b1, 1'b0, 1'b0, 16'd17999, 6'd11, 8'd1, 16'd30000, 16'd0,
                           8'd18, 8'd0));
        queue_item(mk_item(1'b0, 1'b1, 1'b1, 1'b0, 16'd17999, 6'd12, 8'd1, 16'd1000,
                           16'd5000, 8'd19, 8'd29));
        queue_item(mk_item(1'b1, 1'b1, 1'b1, 1'b1, 16'd36000, 6'd63, 8'd255, 16'd65535,
                           16'd0, 8'd0, 8'd255));
        queue_item(mk_item(1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 6'd13, 8'd0, 16'd0, 16'd65535,
                           8'd20, 8'd255));
        queue_item(mk_item(1'b0, 1'b1, 1'b0, 1'b0, 16'd65535, 6'd14, 8'd100, 16'd500, 16'd0,
                           8'd21, 8'd0));
        queue_item(mk_item(1'b1, 1'b1, 1'b0, 1'b1, 16'd18001, 6'd0, 8'd1, 16'd0, 16'd0,
                           8'd22, 8'd0));

        // random phases over several register settings, extremes included
        run_phase(16'd9000, 24'd100, 24'd60000, 24'd500, 400, 38);
        run_phase(16'd0, 24'd0, 24'd16711425, 24'd16711425, 250, 38);
        run_phase(16'd65535, 24'd16711425, 24'd0, 24'd0, 150, 38);
        run_phase(16'd36000, 24'd1000, 24'd200000, 24'd2000, 350, 0);
        repeat (3) begin
            lo = 24'($urandom_range(5000));
            run_phase(16'($urandom), lo, 24'($urandom_range(600000, int'(lo))),
                      24'($urandom_range(1000)), 180, 38);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
